[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// Clocked property wrappers with and without a reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define PVTD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Property checked at every rising edge, reset included.
`define PVTD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/pvtd_pkg.sv]
// ----------------------------------------------------------------------------
// pvtd_pkg
// Types, codes and decode tables of the PVRTC 4bpp texel decoder.
// ----------------------------------------------------------------------------
package pvtd_pkg;

   // texture side limit in blocks, as a power of two; sizes the packet store
   localparam int MAX_LOG2_BLOCKS = 6;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic        op;
      logic [11:0] packet_index;
      logic [63:0] packet_word;
      logic [7:0]  texel_x;
      logic [7:0]  texel_y;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rsp_type;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] a;
   } color_type;

   // expanded neighbor colors, bilinear factors and modulation weights
   typedef struct packed {
      color_type [3:0]      ca;
      color_type [3:0]      cb;
      logic [3:0][4:0]      f;
      logic [3:0][3:0]      w;
   } blend_type;

   function automatic logic [7:0] rep5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] rep4(input logic [3:0] v);
      return {v, v};
   endfunction

   function automatic logic [7:0] rep3(input logic [2:0] v);
      return {v, v, v[2:1]};
   endfunction

   function automatic color_type expand_a(input logic [31:0] hi);
      color_type  c;
      logic [13:0] v;
      v = hi[14:1];
      if (hi[15]) begin
         c = '{r: rep5(v[13:9]), g: rep5(v[8:4]), b: rep4(v[3:0]), a: 8'hff};
      end else begin
         c = '{r: rep4(v[10:7]), g: rep4(v[6:3]), b: rep3(v[2:0]), a: rep3(v[13:11])};
      end
      return c;
   endfunction

   function automatic color_type expand_b(input logic [31:0] hi);
      color_type  c;
      logic [14:0] v;
      v = hi[30:16];
      if (hi[31]) begin
         c = '{r: rep5(v[14:10]), g: rep5(v[9:5]), b: rep5(v[4:0]), a: 8'hff};
      end else begin
         c = '{r: rep4(v[11:8]), g: rep4(v[7:4]), b: rep4(v[3:0]), a: rep3(v[14:12])};
      end
      return c;
   endfunction

   // bilinear factors of the four neighbors, element i for neighbor i
   function automatic logic [3:0][4:0] bilerp_factor(input logic [3:0] q);
      logic [3:0][4:0] f;
      case (q)
         4'd0:    f = {5'd4, 5'd4, 5'd4, 5'd4};
         4'd1:    f = {5'd6, 5'd2, 5'd6, 5'd2};
         4'd2:    f = {5'd0, 5'd8, 5'd0, 5'd8};
         4'd3:    f = {5'd2, 5'd6, 5'd2, 5'd6};
         4'd4:    f = {5'd6, 5'd6, 5'd2, 5'd2};
         4'd5:    f = {5'd9, 5'd3, 5'd3, 5'd1};
         4'd6:    f = {5'd0, 5'd12, 5'd0, 5'd4};
         4'd7:    f = {5'd3, 5'd9, 5'd1, 5'd3};
         4'd8:    f = {5'd0, 5'd0, 5'd8, 5'd8};
         4'd9:    f = {5'd0, 5'd0, 5'd12, 5'd4};
         4'd10:   f = {5'd0, 5'd0, 5'd0, 5'd16};
         4'd11:   f = {5'd0, 5'd0, 5'd4, 5'd12};
         4'd12:   f = {5'd2, 5'd2, 5'd6, 5'd6};
         4'd13:   f = {5'd3, 5'd1, 5'd9, 5'd3};
         4'd14:   f = {5'd0, 5'd4, 5'd0, 5'd12};
         default: f = {5'd1, 5'd3, 5'd3, 5'd9};
      endcase
      return f;
   endfunction

   // {alpha B, alpha A, color B, color A}; index is {punchthrough, code}
   function automatic logic [3:0][3:0] mod_weight(input logic [2:0] idx);
      logic [3:0][3:0] w;
      case (idx)
         3'd0:    w = {4'd0, 4'd8, 4'd0, 4'd8};
         3'd1:    w = {4'd3, 4'd5, 4'd3, 4'd5};
         3'd2:    w = {4'd5, 4'd3, 4'd5, 4'd3};
         3'd3:    w = {4'd8, 4'd0, 4'd8, 4'd0};
         3'd4:    w = {4'd0, 4'd8, 4'd0, 4'd8};
         3'd5:    w = {4'd4, 4'd4, 4'd4, 4'd4};
         3'd6:    w = {4'd0, 4'd0, 4'd4, 4'd4};
         default: w = {4'd8, 4'd0, 4'd8, 4'd0};
      endcase
      return w;
   endfunction

endpackage

[hw/rtl/pvtd_store.sv]
// ----------------------------------------------------------------------------
// pvtd_store
// Packet store in four banks picked by the two low Morton bits.
// ----------------------------------------------------------------------------
module pvtd_store #(
   parameter int AW = 10
) (
   input  logic                 clock,
   input  logic                 adv,
   input  logic                 we,
   input  logic [1:0]           wbank,
   input  logic [AW-1:0]        waddr,
   input  logic [63:0]          wdata,
   input  logic [3:0][AW-1:0]   raddr,
   output logic [3:0][63:0]     rdata
);

   localparam int DEPTH = 1 << AW;

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [63:0] mem [DEPTH];
      logic [63:0] rdata_ff;

      // hold read data while the pipeline is stalled
      always_ff @(posedge clock) begin
         if (adv) begin
            if (we && wbank == 2'(b)) begin
               mem[waddr] <= wdata;
            end
            rdata_ff <= mem[raddr[b]];
         end
      end

      assign rdata[b] = rdata_ff;
   end

endmodule

[hw/rtl/pvtd_blend.sv]
// ----------------------------------------------------------------------------
// pvtd_blend
// Bilinear sums, then modulation weighting into the output register.
// ----------------------------------------------------------------------------
module pvtd_blend
   import pvtd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      adv,
   input  logic      s2_valid,
   input  blend_type s2_data,
   output logic      rsp_valid,
   output rsp_type   rsp_data
);

   logic            s3_valid_ff;
   logic [3:0][11:0] s3_sa_ff, s3_sa_in;
   logic [3:0][11:0] s3_sb_ff, s3_sb_in;
   logic [3:0][3:0]  s3_w_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_data_ff, rsp_data_in;

   // factors sum to 16, so the sum stays below 4096
   function automatic logic [11:0] wsum(input logic [3:0][7:0] c, input logic [3:0][4:0] f);
      logic [11:0] s;
      s = '0;
      for (int i = 0; i < 4; i++) begin
         s = s + 12'(c[i] * f[i]);
      end
      return s;
   endfunction

   always_comb begin
      logic [3:0][7:0] a_ch [4];
      logic [3:0][7:0] b_ch [4];
      for (int i = 0; i < 4; i++) begin
         a_ch[3][i] = s2_data.ca[i].r;  b_ch[3][i] = s2_data.cb[i].r;
         a_ch[2][i] = s2_data.ca[i].g;  b_ch[2][i] = s2_data.cb[i].g;
         a_ch[1][i] = s2_data.ca[i].b;  b_ch[1][i] = s2_data.cb[i].b;
         a_ch[0][i] = s2_data.ca[i].a;  b_ch[0][i] = s2_data.cb[i].a;
      end
      for (int ch = 0; ch < 4; ch++) begin
         s3_sa_in[ch] = wsum(a_ch[ch], s2_data.f);
         s3_sb_in[ch] = wsum(b_ch[ch], s2_data.f);
      end
   end

   function automatic logic [7:0] modulate(input logic [11:0] sa, input logic [11:0] sb,
                                           input logic [3:0] wa, input logic [3:0] wb);
      logic [15:0] s;
      s = 16'(sa * wa) + 16'(sb * wb);
      return s[14:7];
   endfunction

   // channel 3 red ... channel 0 alpha; alpha takes the second weight pair
   always_comb begin
      rsp_data_in.red   = modulate(s3_sa_ff[3], s3_sb_ff[3], s3_w_ff[0], s3_w_ff[1]);
      rsp_data_in.green = modulate(s3_sa_ff[2], s3_sb_ff[2], s3_w_ff[0], s3_w_ff[1]);
      rsp_data_in.blue  = modulate(s3_sa_ff[1], s3_sb_ff[1], s3_w_ff[0], s3_w_ff[1]);
      rsp_data_in.alpha = modulate(s3_sa_ff[0], s3_sb_ff[0], s3_w_ff[2], s3_w_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff  <= s2_valid;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_sa_ff    <= s3_sa_in;
         s3_sb_ff    <= s3_sb_in;
         s3_w_ff     <= s2_data.w;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/pvrtc_4bpp_texel_decoder.sv]
// ----------------------------------------------------------------------------
// pvrtc_4bpp_texel_decoder
// PVRTC 4bpp texel decoder for square textures with a banked packet store.
// ----------------------------------------------------------------------------
// The decoder takes one beat per cycle unless stalled and returns one decoded
// RGBA texel for every query beat; write beats store a packet and return
// nothing. The pipeline is address generation plus store read, color
// expansion, bilinear sums, modulation into the output register. Throughput is
// one beat per cycle because the four neighbor packets of a query fall in four
// different banks (the two low Morton bits) unless the side is one block, so
// each bank serves one read and one write per cycle on separate ports. A stall
// on the result side freezes the whole pipeline; the block keeps taking beats
// as long as the output register is empty or being drained. Queries may only
// touch packets that were written before; the store has no reset.
// ----------------------------------------------------------------------------
module pvrtc_4bpp_texel_decoder
   import pvtd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [2:0] csr_wdata
);

   localparam int BW = MAX_LOG2_BLOCKS;       // block coordinate width
   localparam int AW = 2 * (BW - 1);          // address width of one bank
   localparam logic [2:0] LG_MAX = 3'(MAX_LOG2_BLOCKS);

   logic             adv;
   logic [2:0]       lg_ff;
   logic [2:0]       lg;
   logic [BW-1:0]    mask;
   logic [BW+1:0]    tx, ty;
   logic [BW-1:0]    bx, by, x0, x1, y0, y1;
   logic [3:0][AW-1:0] raddr;
   logic [3:0][63:0] rdata;

   logic             s1_valid_ff;
   logic [3:0]       s1_q_ff;
   logic [3:0][1:0]  s1_sel_ff, s1_sel_in;
   logic [1:0]       s1_own_ff;

   logic             s2_valid_ff;
   blend_type        s2_data_ff, s2_data_in;

   // The whole pipeline moves as one; stall only while a result sits unread.
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         lg_ff <= 3'd6;
      end else if (csr_we) begin
         lg_ff <= csr_wdata;
      end
   end

   // ---- stage 0: wrap coordinates, pick neighbor blocks, bank addresses ----
   always_comb begin
      logic [BW:0]   one_hot;
      logic [BW+1:0] tmask;
      lg      = (lg_ff > LG_MAX) ? LG_MAX : lg_ff;
      one_hot = (BW+1)'(1) << lg;
      mask    = BW'(one_hot - (BW+1)'(1));
      tmask   = {mask, 2'b11};
      tx      = req_data.texel_x[BW+1:0] & tmask;
      ty      = req_data.texel_y[BW+1:0] & tmask;
      bx      = tx[BW+1:2];
      by      = ty[BW+1:2];
      // left or upper half of the block looks back one block
      x0      = ((tx[1] == 1'b0) ? bx - BW'(1) : bx) & mask;
      x1      = (x0 + BW'(1)) & mask;
      y0      = ((ty[1] == 1'b0) ? by - BW'(1) : by) & mask;
      y1      = (y0 + BW'(1)) & mask;
   end

   // neighbor i sits at (i[0] ? x1 : x0, i[1] ? y1 : y0); its bank is {x[0], y[0]}
   always_comb begin
      logic [BW-1:0] xs, ys;
      for (int i = 0; i < 4; i++) begin
         xs = i[0] ? x1 : x0;
         ys = i[1] ? y1 : y0;
         s1_sel_in[i] = {xs[0], ys[0]};
      end
      // bank {xb, yb} reads the neighbor whose low bits match
      for (int b = 0; b < 4; b++) begin
         xs = (x0[0] == b[1]) ? x0 : x1;
         ys = (y0[0] == b[0]) ? y0 : y1;
         for (int k = 0; k < BW - 1; k++) begin
            raddr[b][2*k+1] = xs[k+1];
            raddr[b][2*k]   = ys[k+1];
         end
      end
   end

   pvtd_store #(
      .AW (AW)
   ) u_store (
      .clock (clock),
      .adv   (adv),
      .we    (req_valid && req_data.op == OP_WRITE),
      .wbank (req_data.packet_index[1:0]),
      .waddr (req_data.packet_index[2*BW-1:2]),
      .wdata (req_data.packet_word),
      .raddr (raddr),
      .rdata (rdata)
   );

   // Write beats drop out here; only queries travel on.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid && req_data.op == OP_QUERY;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_q_ff    <= {ty[1:0], tx[1:0]};
         s1_sel_ff  <= s1_sel_in;
         s1_own_ff  <= {bx[0], by[0]};
         s2_data_ff <= s2_data_in;
      end
   end

   // ---- stage 1: route bank data to neighbors, expand colors, look up weights ----
   always_comb begin
      logic [63:0] own;
      logic [1:0]  code;
      for (int i = 0; i < 4; i++) begin
         s2_data_in.ca[i] = expand_a(rdata[s1_sel_ff[i]][63:32]);
         s2_data_in.cb[i] = expand_b(rdata[s1_sel_ff[i]][63:32]);
      end
      s2_data_in.f = bilerp_factor(s1_q_ff);
      // the texel's own block is always one of the four neighbors
      own  = rdata[s1_own_ff];
      code = own[{s1_q_ff, 1'b0} +: 2];
      s2_data_in.w = mod_weight({own[32], code});
   end

   // ---- stages 2 and 3: bilinear sums, modulation, output register ----
   pvtd_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .s2_valid  (s2_valid_ff),
      .s2_data   (s2_data_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[hw/rtl/pvtd_checker.sv]
// ----------------------------------------------------------------------------
// pvtd_checker
// Port-level checks of the texel decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pvtd_checker
   import pvtd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   `PVTD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result after reset")

   `PVTD_ASSERT(a_stall_cause, clock, reset, req_stall |-> (rsp_valid && rsp_stall), "needless stall")

   `PVTD_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid, "result dropped")

   `PVTD_ASSERT(a_rsp_stable, clock, reset, (rsp_valid && rsp_stall) |=> $stable(rsp_data), "result moved")

endmodule

bind pvrtc_4bpp_texel_decoder pvtd_checker u_pvtd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[dv/tb_pvrtc_4bpp_texel_decoder.sv]
// ----------------------------------------------------------------------------
// tb_pvrtc_4bpp_texel_decoder
// Self-checking bench for the PVRTC 4bpp texel decoder: a bursty driver feeds
// packet writes and texel queries, a monitor compares every decoded texel with
// a behavioral texel decoder kept inside the bench, under a stalling receiver.
// ----------------------------------------------------------------------------
module tb_pvrtc_4bpp_texel_decoder
   import pvtd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LG     = MAX_LOG2_BLOCKS;
   localparam int DEPTH      = 1 << (2 * MAX_LG);
   localparam int LATENCY    = 4;
   localparam int CYCLE_CAP  = 400000;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;
   logic       csr_we;
   logic [2:0] csr_wdata;

   pvrtc_4bpp_texel_decoder dut (.*);

   // shadow of the packet store and the side register
   logic [63:0] shadow_pkt [DEPTH];
   bit          shadow_set [DEPTH];
   logic [2:0]  side_lg;

   req_type beats_pending [$];
   rsp_type texels_due [$];
   int      error_count;
   int      cycle_count;
   int      queries_sent;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // --------------------------------------------------------------------------
   // Behavioral decoder
   // --------------------------------------------------------------------------
   function automatic logic [7:0] widen5(logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] widen4(logic [3:0] v);
      return {v, v};
   endfunction

   function automatic logic [7:0] widen3(logic [2:0] v);
      return {v, v, v[2:1]};
   endfunction

   // colors as {r, g, b, a}; sel picks color B
   function automatic void unpack_colors(logic [31:0] hi, bit sel, output int c[4]);
      logic [14:0] v;
      if (!sel) begin
         v = {1'b0, hi[14:1]};
         if (hi[15]) begin
            c = '{widen5(v[13:9]), widen5(v[8:4]), widen4(v[3:0]), 255};
         end else begin
            c = '{widen4(v[10:7]), widen4(v[6:3]), widen3(v[2:0]), widen3(v[13:11])};
         end
      end else begin
         v = hi[30:16];
         if (hi[31]) begin
            c = '{widen5(v[14:10]), widen5(v[9:5]), widen5(v[4:0]), 255};
         end else begin
            c = '{widen4(v[11:8]), widen4(v[7:4]), widen4(v[3:0]), widen3(v[14:12])};
         end
      end
   endfunction

   function automatic int interleave(int bx, int by);
      int r;
      r = 0;
      for (int i = 0; i < MAX_LG; i++) begin
         r |= ((bx >> i) & 1) << (2 * i + 1);
         r |= ((by >> i) & 1) << (2 * i);
      end
      return r;
   endfunction

   function automatic int side_log();
      return (side_lg > MAX_LG) ? MAX_LG : int'(side_lg);
   endfunction

   function automatic rsp_type decode_texel(logic [7:0] x, logic [7:0] y);
      int lg, msk, tx, ty, bx, by, px, py, x0, x1, y0, y1, q, code, wi;
      int nb [4];
      int sa [4];
      int sb [4];
      int ca [4];
      int cb [4];
      int fac [16][4];
      int wt [8][4];
      logic [63:0] own;
      int o [4];
      rsp_type r;
      fac = '{'{4,4,4,4}, '{2,6,2,6}, '{8,0,8,0}, '{6,2,6,2},
              '{2,2,6,6}, '{1,3,3,9}, '{4,0,12,0}, '{3,1,9,3},
              '{8,8,0,0}, '{4,12,0,0}, '{16,0,0,0}, '{12,4,0,0},
              '{6,6,2,2}, '{3,9,1,3}, '{12,0,4,0}, '{9,3,3,1}};
      wt = '{'{8,0,8,0}, '{5,3,5,3}, '{3,5,3,5}, '{0,8,0,8},
             '{8,0,8,0}, '{4,4,4,4}, '{4,4,0,0}, '{0,8,0,8}};
      lg  = side_log();
      msk = (1 << lg) - 1;
      tx  = int'(x) & ((4 << lg) - 1);
      ty  = int'(y) & ((4 << lg) - 1);
      bx = tx >> 2; by = ty >> 2; px = tx & 3; py = ty & 3;
      x0 = ((px < 2) ? bx - 1 : bx) & msk;
      x1 = (x0 + 1) & msk;
      y0 = ((py < 2) ? by - 1 : by) & msk;
      y1 = (y0 + 1) & msk;
      nb = '{interleave(x0, y0), interleave(x1, y0), interleave(x0, y1), interleave(x1, y1)};
      q  = py * 4 + px;
      sa = '{0, 0, 0, 0};
      sb = '{0, 0, 0, 0};
      for (int i = 0; i < 4; i++) begin
         unpack_colors(shadow_pkt[nb[i]][63:32], 1'b0, ca);
         unpack_colors(shadow_pkt[nb[i]][63:32], 1'b1, cb);
         for (int ch = 0; ch < 4; ch++) begin
            sa[ch] += ca[ch] * fac[q][i];
            sb[ch] += cb[ch] * fac[q][i];
         end
      end
      own  = shadow_pkt[interleave(bx, by)];
      code = int'(own >> (2 * q)) & 3;
      wi   = (int'(own[32]) << 2) | code;
      for (int ch = 0; ch < 3; ch++) o[ch] = ((sa[ch] * wt[wi][0] + sb[ch] * wt[wi][1]) >> 7) & 255;
      o[3] = ((sa[3] * wt[wi][2] + sb[3] * wt[wi][3]) >> 7) & 255;
      r.red = 8'(o[0]); r.green = 8'(o[1]); r.blue = 8'(o[2]); r.alpha = 8'(o[3]);
      return r;
   endfunction

   // --------------------------------------------------------------------------
   // Stimulus helpers: every query only touches written packets
   // --------------------------------------------------------------------------
   function automatic bit texel_covered(logic [7:0] x, logic [7:0] y);
      int lg, msk, bx, by, px, py, x0, y0, tx, ty;
      lg  = side_log();
      msk = (1 << lg) - 1;
      tx = int'(x) & ((4 << lg) - 1);
      ty = int'(y) & ((4 << lg) - 1);
      bx = tx >> 2; by = ty >> 2; px = tx & 3; py = ty & 3;
      x0 = ((px < 2) ? bx - 1 : bx) & msk;
      y0 = ((py < 2) ? by - 1 : by) & msk;
      return shadow_set[interleave(x0, y0)] && shadow_set[interleave((x0 + 1) & msk, y0)] &&
             shadow_set[interleave(x0, (y0 + 1) & msk)] &&
             shadow_set[interleave((x0 + 1) & msk, (y0 + 1) & msk)] &&
             shadow_set[interleave(bx, by)];
   endfunction

   // queue a beat and advance the shadow the way the block will
   task automatic push_beat(req_type b);
      beats_pending.push_back(b);
      if (b.op == OP_WRITE) begin
         shadow_pkt[b.packet_index] = b.packet_word;
         shadow_set[b.packet_index] = 1'b1;
      end else begin
         texels_due.push_back(decode_texel(b.texel_x, b.texel_y));
         queries_sent++;
      end
   endtask

   function automatic logic [63:0] random_packet();
      return {$urandom, $urandom};
   endfunction

   task automatic push_write(int idx, logic [63:0] w);
      req_type b;
      b = '0;
      b.op = OP_WRITE;
      b.packet_index = idx[11:0];
      b.packet_word = w;
      push_beat(b);
   endtask

   task automatic push_query(logic [7:0] x, logic [7:0] y);
      req_type b;
      b = '0;
      b.op = OP_QUERY;
      b.texel_x = x;
      b.texel_y = y;
      b.packet_index = 12'($urandom);
      b.packet_word = random_packet();
      push_beat(b);
   endtask

   // fill a window of blocks around the origin, wrap side included
   task automatic fill_texture();
      int side;
      int bx, by;
      side = 1 << side_log();
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            bx = ((i == 3) ? side - 1 : i) & (side - 1);
            by = ((j == 3) ? side - 1 : j) & (side - 1);
            push_write(interleave(bx, by), random_packet());
         end
      end
   endtask

   // random query that only lands on written blocks
   task automatic push_random_query();
      logic [7:0] x, y;
      do begin
         x = 8'($urandom);
         y = 8'($urandom);
      end while (!texel_covered(x, y));
      push_query(x, y);
   endtask

   // wait for the pipeline to drain, then hold off for trailing writes
   task automatic drain();
      while (beats_pending.size() != 0 || texels_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_side(logic [2:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      side_lg    = v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // --------------------------------------------------------------------------
   // Sequence
   // --------------------------------------------------------------------------
   initial begin
      logic [2:0] plan [6];
      plan = '{3'd0, 3'd7, 3'd1, 3'd2, 3'd3, 3'd6};
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      side_lg = 3'd6;
      error_count = 0;
      queries_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: 2x2 blocks, all codes written in both modes, every punchthrough code queried, corners and wrap
      write_side(3'd1);
      push_write(0, 64'h0000_0000_E4E4_E4E4);                    // mode 0, all codes
      push_write(1, 64'hFFFF_FFFF_E4E4_E4E4);                    // opaque, punchthrough
      push_write(2, 64'h7FFF_0001_1B1B_1B1B);                    // translucent B max
      push_write(3, 64'h8000_FFFE_FFFF_FFFF);                    // opaque B, opaque A
      push_query(8'd0, 8'd0);
      push_query(8'd255, 8'd255);
      push_query(8'd7, 8'd0);
      push_query(8'd0, 8'd7);
      push_query(8'd5, 8'd6);
      for (int i = 0; i < 16; i++) push_query(i[7:0] & 8'd3 | 8'd4, i[7:0] >> 2);
      push_query(8'h80, 8'h40);

      // random: several sides including the extremes and an oversized value
      foreach (plan[k]) begin
         write_side(plan[k]);
         fill_texture();
         for (int i = 0; i < 50; i++) begin
            if ($urandom_range(0, 5) == 0) push_write($urandom, random_packet());
            else push_random_query();
         end
      end
      drain();
      if (error_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Driver: bursts of beats with random gaps; hold the beat while stalled
   // --------------------------------------------------------------------------
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         req_data   <= '0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         automatic bit taken = req_valid && !req_stall;
         automatic bit busy  = req_valid && !taken;
         if (taken) void'(beats_pending.pop_front());
         if (!busy) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (beats_pending.size() > 0) begin
               req_valid <= 1'b1;
               req_data  <= beats_pending[0];
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 20);
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall pattern: alternate calm and choppy stretches
   int stall_phase;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= (stall_phase + 1) % 64;
         if (stall_phase < 24) rsp_stall <= 1'b0;
         else if (stall_phase < 48) rsp_stall <= ($urandom_range(0, 2) == 0);
         else rsp_stall <= ($urandom_range(0, 3) != 0);
      end
   end

   // --------------------------------------------------------------------------
   // Monitor: compare each texel beat with the oldest expectation
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count > CYCLE_CAP) begin
            $display("timeout at cycle %0d", cycle_count);
            $display("status: fail");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (texels_due.size() == 0) begin
               report_mismatch("unexpected texel", 1, 0);
            end else begin
               automatic rsp_type want = texels_due.pop_front();
               if (rsp_data.red !== want.red) report_mismatch("red", rsp_data.red, want.red);
               if (rsp_data.green !== want.green)
                  report_mismatch("green", rsp_data.green, want.green);
               if (rsp_data.blue !== want.blue) report_mismatch("blue", rsp_data.blue, want.blue);
               if (rsp_data.alpha !== want.alpha)
                  report_mismatch("alpha", rsp_data.alpha, want.alpha);
            end
         end
      end
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/pvtd_pkg.sv
hw/rtl/pvtd_store.sv
hw/rtl/pvtd_blend.sv
hw/rtl/pvrtc_4bpp_texel_decoder.sv
hw/rtl/pvtd_checker.sv
dv/tb_pvrtc_4bpp_texel_decoder.sv
